@@ src/fbpa_pkg.sv @@
// shared types and constants of the fixed block pool allocator
package fbpa_pkg;

  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;
  localparam int OFF_W    = 20;
  localparam int CNT_W    = 9;
  localparam int CFG_W    = 13;
  localparam int SZ_W     = CFG_W + 1;
  localparam int CFG_A_W  = 1;
  localparam int ALIGN    = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_POOL_RST = 256;
  localparam int CFG_SIZE_RST = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_RESET = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_BAD_FREE  = 2'd2
  } status_e;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_POOL_BLOCKS = 1'd0,
    CFG_BLOCK_BYTES = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OFFS,
    S_DIV,
    S_EMIT
  } state_e;

endpackage

@@ src/fbpa_stack_ram.sv @@
// single-port-write, single-port-read stack memory with registered read data
module fbpa_stack_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fbpa_div.sv @@
// bit-serial restoring divider turning a byte offset into a block index
module fbpa_div #(
  parameter int IW = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fbpa_pkg::OFF_W-1:0]   dividend_i,
  input  logic [fbpa_pkg::SZ_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [IW-1:0]                quot_o,
  output logic                         rem_zero_o
);

  localparam int DW = fbpa_pkg::SZ_W + IW;
  localparam int CW = $clog2(IW + 1);

  logic [fbpa_pkg::OFF_W-1:0] rem_q, rem_d;
  logic [DW-1:0]              dsh_q, dsh_d;
  logic [IW-1:0]              quot_q, quot_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       fits;

  assign fits = 32'(rem_q) >= 32'(dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dsh_d  = DW'(divisor_i) << (IW - 1);
      quot_d = '0;
      cnt_d  = CW'(IW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsh_q[fbpa_pkg::OFF_W-1:0];
      end
      quot_d = (quot_q << 1) | IW'(fits);
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o     = done_q;
  assign quot_o     = quot_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// fixed block pool allocator: control, counters and result register
// one item at a time; a successful allocate goes through S_OFFS and then S_EMIT before its result
// is registered, a failed allocate, a pool reset or an unused kind goes straight to S_EMIT
// free runs the offset through a bit-serial divider, one quotient bit per cycle, then S_EMIT
// the freed index stack lives in a memory with a registered read
// reset and any register write empty the pool at once, though a counter update by an item
// in the same cycle wins over the write; the stack memory is not cleared
module fixed_block_pool_allocator #(
  parameter int POOL_DEPTH      = 256,
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // free_offset[19:0], zero pad
  input  logic [fbpa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // kind[1:0]
  input  logic [fbpa_pkg::KIND_W-1:0]        s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // alloc_offset[19:0], in_use[28:20], peak_in_use[37:29], zero pad
  output logic [fbpa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [fbpa_pkg::STAT_W-1:0]        m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [fbpa_pkg::CFG_A_W-1:0]       cfg_addr_i,
  input  logic [fbpa_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int CNT_W    = fbpa_pkg::CNT_W;
  localparam int OFF_W    = fbpa_pkg::OFF_W;
  localparam int SZ_W     = fbpa_pkg::SZ_W;
  localparam int CFG_W    = fbpa_pkg::CFG_W;
  localparam int POOL_MAX = (POOL_DEPTH < 511) ? POOL_DEPTH : 511;
  localparam int IW       = $clog2(POOL_MAX);
  localparam int POOL_RST = (POOL_MAX < fbpa_pkg::CFG_POOL_RST) ? POOL_MAX
                                                                 : fbpa_pkg::CFG_POOL_RST;
  localparam int LIM_W    = CNT_W + SZ_W;
  localparam int MUL_W    = IW + SZ_W;

  fbpa_pkg::state_e  state_q, state_d;
  fbpa_pkg::status_e res_status_q, res_status_d;
  fbpa_pkg::status_e out_status_q, out_status_d;

  logic [CNT_W-1:0] pool_q, pool_d;
  logic [SZ_W-1:0]  size_q, size_d;
  logic [CNT_W-1:0] freed_q, freed_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;
  logic [CNT_W-1:0] alloc_q, alloc_d;
  logic [CNT_W-1:0] peak_q, peak_d;
  logic [LIM_W-1:0] limit_q;
  logic [OFF_W-1:0] off_q, off_d;
  logic             from_stack_q, from_stack_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [OFF_W-1:0] res_aoff_q, res_aoff_d;
  logic             out_valid_q, out_valid_d;
  logic [OFF_W-1:0] out_aoff_q, out_aoff_d;
  logic [CNT_W-1:0] out_inuse_q, out_inuse_d;
  logic [CNT_W-1:0] out_peak_q, out_peak_d;

  logic             in_xfer;
  logic             emit_ok;
  fbpa_pkg::kind_e  kind;
  logic [OFF_W-1:0] in_off;
  logic [CNT_W-1:0] alloc_inc;
  logic [CNT_W-1:0] cfg_pool;
  logic [CFG_W-1:0] cfg_bytes;
  logic [SZ_W-1:0]  cfg_round;
  logic [IW-1:0]    idx_src;
  logic [MUL_W-1:0] aoff_full;

  logic             mem_we;
  logic             mem_re;
  logic [IW-1:0]    mem_waddr;
  logic [IW-1:0]    mem_raddr;
  logic [IW-1:0]    mem_rdata;

  logic             div_start;
  logic             div_done;
  logic [IW-1:0]    div_quot;
  logic             div_rem_zero;

  assign s_axis_tready = (state_q == fbpa_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign emit_ok       = !out_valid_q || m_axis_tready;
  assign kind          = fbpa_pkg::kind_e'(s_axis_tuser);
  assign in_off        = s_axis_tdata[OFF_W-1:0];
  assign alloc_inc     = alloc_q + CNT_W'(1);
  assign mem_waddr     = IW'(freed_q);
  assign mem_raddr     = IW'(freed_q - CNT_W'(1));
  assign idx_src       = from_stack_q ? mem_rdata : idx_q;
  assign aoff_full     = MUL_W'(idx_src) * MUL_W'(size_q);

  // effective register values
  always_comb begin
    cfg_pool = CNT_W'(cfg_wdata_i);
    if (32'(cfg_pool) > POOL_MAX) begin
      cfg_pool = CNT_W'(POOL_MAX);
    end
    cfg_bytes = cfg_wdata_i;
    if (cfg_bytes == '0) begin
      cfg_bytes = CFG_W'(1);
    end
    if (32'(cfg_bytes) > MAX_BLOCK_BYTES) begin
      cfg_bytes = CFG_W'(MAX_BLOCK_BYTES);
    end
    cfg_round = (SZ_W'(cfg_bytes) + SZ_W'(fbpa_pkg::ALIGN - 1))
              & ~SZ_W'(fbpa_pkg::ALIGN - 1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbpa_pkg::S_IDLE: begin
        if (in_xfer) begin
          unique case (kind)
            fbpa_pkg::KIND_ALLOC: begin
              state_d = (alloc_q >= pool_q) ? fbpa_pkg::S_EMIT : fbpa_pkg::S_OFFS;
            end
            fbpa_pkg::KIND_FREE: state_d = fbpa_pkg::S_DIV;
            default:             state_d = fbpa_pkg::S_EMIT;
          endcase
        end
      end
      fbpa_pkg::S_OFFS: state_d = fbpa_pkg::S_EMIT;
      fbpa_pkg::S_DIV: begin
        if (div_done) begin
          state_d = fbpa_pkg::S_EMIT;
        end
      end
      fbpa_pkg::S_EMIT: begin
        if (emit_ok) begin
          state_d = fbpa_pkg::S_IDLE;
        end
      end
      default: state_d = fbpa_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pool_d       = pool_q;
    size_d       = size_q;
    freed_d      = freed_q;
    fresh_d      = fresh_q;
    alloc_d      = alloc_q;
    peak_d       = peak_q;
    off_d        = off_q;
    from_stack_d = from_stack_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_aoff_d   = res_aoff_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_aoff_d   = out_aoff_q;
    out_inuse_d  = out_inuse_q;
    out_peak_d   = out_peak_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    div_start    = 1'b0;

    if (cfg_we_i) begin
      unique case (fbpa_pkg::cfg_reg_e'(cfg_addr_i))
        fbpa_pkg::CFG_POOL_BLOCKS: pool_d = cfg_pool;
        fbpa_pkg::CFG_BLOCK_BYTES: size_d = cfg_round;
        default: ;
      endcase
      freed_d = '0;
      fresh_d = '0;
      alloc_d = '0;
      peak_d  = '0;
    end

    unique case (state_q)
      fbpa_pkg::S_IDLE: begin
        if (in_xfer) begin
          off_d        = in_off;
          res_status_d = fbpa_pkg::STAT_OK;
          res_aoff_d   = '0;
          unique case (kind)
            fbpa_pkg::KIND_ALLOC: begin
              if (alloc_q >= pool_q) begin
                res_status_d = fbpa_pkg::STAT_EXHAUSTED;
              end else begin
                alloc_d = alloc_inc;
                if (peak_q < alloc_inc) begin
                  peak_d = alloc_inc;
                end
                if (freed_q != '0) begin
                  freed_d      = freed_q - CNT_W'(1);
                  mem_re       = 1'b1;
                  from_stack_d = 1'b1;
                end else begin
                  idx_d        = IW'(fresh_q);
                  fresh_d      = fresh_q + CNT_W'(1);
                  from_stack_d = 1'b0;
                end
              end
            end
            fbpa_pkg::KIND_FREE: div_start = 1'b1;
            fbpa_pkg::KIND_RESET: begin
              freed_d = '0;
              fresh_d = '0;
              alloc_d = '0;
              peak_d  = '0;
            end
            default: ;
          endcase
        end
      end
      fbpa_pkg::S_OFFS: res_aoff_d = OFF_W'(aoff_full);
      fbpa_pkg::S_DIV: begin
        if (div_done) begin
          if (alloc_q == '0 || !div_rem_zero || 32'(off_q) >= 32'(limit_q)) begin
            res_status_d = fbpa_pkg::STAT_BAD_FREE;
          end else begin
            mem_we  = 1'b1;
            freed_d = freed_q + CNT_W'(1);
            alloc_d = alloc_q - CNT_W'(1);
          end
        end
      end
      fbpa_pkg::S_EMIT: begin
        if (emit_ok) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_aoff_d   = res_aoff_q;
          out_inuse_d  = alloc_q;
          out_peak_d   = peak_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbpa_pkg::S_IDLE;
      pool_q      <= CNT_W'(POOL_RST);
      size_q      <= SZ_W'(fbpa_pkg::CFG_SIZE_RST);
      freed_q     <= '0;
      fresh_q     <= '0;
      alloc_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pool_q      <= pool_d;
      size_q      <= size_d;
      freed_q     <= freed_d;
      fresh_q     <= fresh_d;
      alloc_q     <= alloc_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q      <= LIM_W'(pool_q) * LIM_W'(size_q);
    off_q        <= off_d;
    from_stack_q <= from_stack_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_aoff_q   <= res_aoff_d;
    out_status_q <= out_status_d;
    out_aoff_q   <= out_aoff_d;
    out_inuse_q  <= out_inuse_d;
    out_peak_q   <= out_peak_d;
  end

  fbpa_stack_ram #(
    .DEPTH (POOL_MAX),
    .WIDTH (IW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (div_quot),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fbpa_div #(
    .IW (IW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_off),
    .divisor_i  (size_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_zero_o (div_rem_zero)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {
    (fbpa_pkg::OUT_TDATA_W - OFF_W - 2 * CNT_W)'(0),
    out_peak_q, out_inuse_q, out_aoff_q
  };

endmodule
